FILE: design/pcor_pkg.sv
// ----------------------------------------------------------------------------
// pcor_pkg: shared types and constants of the occupancy rasterizer
// Request and response payloads, operation and cell codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcor_pkg;

   localparam int MAX_COLS_DEFAULT = 256;
   localparam int MAX_ROWS_DEFAULT = 256;

   localparam logic [15:0] CELL_SIZE_RESET = 16'd100;

   localparam logic [2:0] OP_BOUND    = 3'd0;
   localparam logic [2:0] OP_GROUND   = 3'd1;
   localparam logic [2:0] OP_OBSTACLE = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
   localparam logic [1:0] CELL_FREE     = 2'd1;
   localparam logic [1:0] CELL_OCCUPIED = 2'd2;

   localparam logic signed [7:0] VALUE_UNKNOWN  = -8'sd1;
   localparam logic signed [7:0] VALUE_FREE     = 8'sd0;
   localparam logic signed [7:0] VALUE_OCCUPIED = 8'sd100;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [23:0] point_x_mm;
      logic signed [23:0] point_y_mm;
      logic [7:0]         read_row;
      logic [7:0]         read_col;
   } req_payload_type;

   typedef struct packed {
      logic signed [7:0]  cell_value;
      logic               point_dropped;
      logic [8:0]         map_width;
      logic [8:0]         map_height;
      logic signed [23:0] origin_x_mm;
      logic signed [23:0] origin_y_mm;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_BOX,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_PLACE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_WIDTH,
      SEL_HEIGHT,
      SEL_COL,
      SEL_ROW
   } div_sel_type;

   typedef struct packed {
      logic        clr_we;
      logic        box_clear;
      logic        box_update;
      logic        req_load;
      logic        div_start;
      logic        div_latch;
      logic        place_write;
      logic        mem_read;
      logic        rsp_load;
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       div_done;
      logic [2:0] operation;
   } status_type;

endpackage

FILE: design/pcor_divider.sv
// ----------------------------------------------------------------------------
// pcor_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module pcor_divider #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      fits = trial >= {1'b0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/pcor_datapath.sv
// ----------------------------------------------------------------------------
// pcor_datapath: bounding box, grid memory and index arithmetic
// Holds the box extents, the grid memory with its clearing counter, the
// divider operand selection and the response register.
// ----------------------------------------------------------------------------
module pcor_datapath #(
   parameter int MAX_COLS = pcor_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = pcor_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pcor_pkg::cmd_type         cmd,
   output pcor_pkg::status_type      status,
   input  pcor_pkg::req_payload_type req_payload,
   input  logic [15:0]               cell_size,
   output pcor_pkg::rsp_payload_type rsp_payload
);

   localparam int WID_W  = $clog2(MAX_COLS + 1);
   localparam int HGT_W  = $clog2(MAX_ROWS + 1);
   localparam int SZ_W   = (WID_W > HGT_W) ? WID_W : HGT_W;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = SZ_W + 16;
   localparam int NUM_W  = ((PROD_W > 26) ? PROD_W : 26) + 2;
   localparam int DVS_W  = 17;
   localparam logic [NUM_W-1:0] MAX_COLS_Q = NUM_W'(MAX_COLS);
   localparam logic [NUM_W-1:0] MAX_ROWS_Q = NUM_W'(MAX_ROWS);

   pcor_pkg::req_payload_type req_ff;
   pcor_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic signed [23:0] least_x_ff, least_x_in, greatest_x_ff, greatest_x_in;
   logic signed [23:0] least_y_ff, least_y_in, greatest_y_ff, greatest_y_in;
   logic               started_ff, started_in;
   logic [WID_W-1:0]   w_ff;
   logic [HGT_W-1:0]   h_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic               col_ok_ff, row_ok_ff, num_neg_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [1:0]         rd_ff;
   logic [1:0]         grid_mem [DEPTH];

   logic [15:0]        cell_eff;
   logic [16:0]        den;
   logic               axis_y, is_place;
   logic signed [23:0] p_sel, lo_sel, hi_sel;
   logic [SZ_W-1:0]    size_sel;
   logic [24:0]        span;
   logic [PROD_W-1:0]  prod;
   logic [NUM_W-1:0]   num, mag, dividend, quo;
   logic [DVS_W-1:0]   divisor;
   logic               div_done, place_ok, read_in_range, place_hit;
   logic [ADDR_W-1:0]  place_addr, read_addr;
   logic [1:0]         place_code;

   pcor_divider #(
      .DVD_W(NUM_W),
      .DVS_W(DVS_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (divisor),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      cell_eff = (cell_size == 16'd0) ? 16'd1 : cell_size;
      den = {cell_eff, 1'b0};
      axis_y = (cmd.div_sel == pcor_pkg::SEL_HEIGHT) || (cmd.div_sel == pcor_pkg::SEL_ROW);
      is_place = (cmd.div_sel == pcor_pkg::SEL_COL) || (cmd.div_sel == pcor_pkg::SEL_ROW);
      p_sel = axis_y ? req_ff.point_y_mm : req_ff.point_x_mm;
      lo_sel = axis_y ? least_y_ff : least_x_ff;
      hi_sel = axis_y ? greatest_y_ff : greatest_x_ff;
      size_sel = axis_y ? SZ_W'(h_ff) : SZ_W'(w_ff);
      span = {hi_sel[23], hi_sel} - {lo_sel[23], lo_sel};
      prod = PROD_W'(size_sel[SZ_W-1:1]) * PROD_W'(den);
      num = {{(NUM_W-25){p_sel[23]}}, p_sel, 1'b0}
          - {{(NUM_W-24){lo_sel[23]}}, lo_sel}
          - {{(NUM_W-24){hi_sel[23]}}, hi_sel}
          + {{(NUM_W-PROD_W){1'b0}}, prod};
      mag = num[NUM_W-1] ? (~num + 1'b1) : num;
      dividend = is_place ? mag : {{(NUM_W-25){1'b0}}, span};
      divisor = is_place ? den : {1'b0, cell_eff};
      place_ok = (!num_neg_ff || (quo == '0))
               && (quo < {{(NUM_W-SZ_W){1'b0}}, size_sel});
   end

   always_comb begin
      least_x_in = least_x_ff;
      greatest_x_in = greatest_x_ff;
      least_y_in = least_y_ff;
      greatest_y_in = greatest_y_ff;
      started_in = started_ff;
      if (cmd.box_clear) begin
         least_x_in = '0;
         greatest_x_in = '0;
         least_y_in = '0;
         greatest_y_in = '0;
         started_in = 1'b0;
      end else if (cmd.box_update) begin
         started_in = 1'b1;
         if (!started_ff) begin
            least_x_in = req_ff.point_x_mm;
            greatest_x_in = req_ff.point_x_mm;
            least_y_in = req_ff.point_y_mm;
            greatest_y_in = req_ff.point_y_mm;
         end else begin
            if (req_ff.point_x_mm > greatest_x_ff) greatest_x_in = req_ff.point_x_mm;
            if (req_ff.point_x_mm < least_x_ff) least_x_in = req_ff.point_x_mm;
            if (req_ff.point_y_mm > greatest_y_ff) greatest_y_in = req_ff.point_y_mm;
            if (req_ff.point_y_mm < least_y_ff) least_y_in = req_ff.point_y_mm;
         end
      end
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clr_we) begin
         clr_cnt_in = (clr_cnt_ff == ADDR_W'(DEPTH - 1)) ? '0 : clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         least_x_ff <= '0;
         greatest_x_ff <= '0;
         least_y_ff <= '0;
         greatest_y_ff <= '0;
         started_ff <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         least_x_ff <= least_x_in;
         greatest_x_ff <= greatest_x_in;
         least_y_ff <= least_y_in;
         greatest_y_ff <= greatest_y_in;
         started_ff <= started_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_payload;
      end
      if (cmd.div_start) begin
         num_neg_ff <= is_place && num[NUM_W-1];
      end
      if (cmd.div_latch) begin
         unique case (cmd.div_sel)
            pcor_pkg::SEL_WIDTH: begin
               w_ff <= !started_ff ? '0
                     : ((quo > MAX_COLS_Q) ? WID_W'(MAX_COLS) : quo[WID_W-1:0]);
            end
            pcor_pkg::SEL_HEIGHT: begin
               h_ff <= !started_ff ? '0
                     : ((quo > MAX_ROWS_Q) ? HGT_W'(MAX_ROWS) : quo[HGT_W-1:0]);
            end
            pcor_pkg::SEL_COL: begin
               col_ff <= quo[COL_W-1:0];
               col_ok_ff <= place_ok;
            end
            pcor_pkg::SEL_ROW: begin
               row_ff <= quo[ROW_W-1:0];
               row_ok_ff <= place_ok;
            end
         endcase
      end
   end

   always_comb begin
      place_hit = col_ok_ff && row_ok_ff;
      place_addr = ADDR_W'(32'(row_ff) * 32'(MAX_COLS) + 32'(col_ff));
      read_addr = ADDR_W'(32'(req_ff.read_row) * 32'(MAX_COLS) + 32'(req_ff.read_col));
      place_code = (req_ff.operation == pcor_pkg::OP_GROUND)
                 ? pcor_pkg::CELL_FREE : pcor_pkg::CELL_OCCUPIED;
      read_in_range = (32'(req_ff.read_row) < 32'(h_ff))
                   && (32'(req_ff.read_col) < 32'(w_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         grid_mem[clr_cnt_ff] <= pcor_pkg::CELL_UNKNOWN;
      end else if (cmd.place_write && place_hit) begin
         grid_mem[place_addr] <= place_code;
      end
      if (cmd.mem_read) begin
         rd_ff <= grid_mem[read_addr];
      end
   end

   always_comb begin
      rsp_in.cell_value = 8'sd0;
      rsp_in.point_dropped = 1'b0;
      if (req_ff.operation == pcor_pkg::OP_READ) begin
         rsp_in.cell_value = pcor_pkg::VALUE_UNKNOWN;
         if (read_in_range) begin
            if (rd_ff == pcor_pkg::CELL_FREE) begin
               rsp_in.cell_value = pcor_pkg::VALUE_FREE;
            end else if (rd_ff == pcor_pkg::CELL_OCCUPIED) begin
               rsp_in.cell_value = pcor_pkg::VALUE_OCCUPIED;
            end
         end
      end
      if ((req_ff.operation == pcor_pkg::OP_GROUND)
            || (req_ff.operation == pcor_pkg::OP_OBSTACLE)) begin
         rsp_in.point_dropped = !place_hit;
      end
      rsp_in.map_width = 9'(w_ff);
      rsp_in.map_height = 9'(h_ff);
      rsp_in.origin_x_mm = least_x_ff;
      rsp_in.origin_y_mm = least_y_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;
   assign status.clr_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign status.div_done = div_done;
   assign status.operation = req_ff.operation;

endmodule

FILE: design/pcor_controller.sv
// ----------------------------------------------------------------------------
// pcor_controller: sequencing state machine
// Accepts a request, steps the datapath through box update, clearing pass,
// divisions and memory access, and hands the response to the output.
// ----------------------------------------------------------------------------
module pcor_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_operation,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcor_pkg::cmd_type    cmd,
   input  pcor_pkg::status_type status
);

   pcor_pkg::state_type   state_ff, state_in;
   pcor_pkg::div_sel_type step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;
   logic                  is_place_op;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_place_op = (status.operation == pcor_pkg::OP_GROUND)
                     || (status.operation == pcor_pkg::OP_OBSTACLE);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         pcor_pkg::ST_INIT: begin
            if (status.clr_last) state_in = pcor_pkg::ST_IDLE;
         end
         pcor_pkg::ST_IDLE: begin
            if (req_valid) begin
               step_in = pcor_pkg::SEL_WIDTH;
               if (req_operation == pcor_pkg::OP_CLEAR) begin
                  state_in = pcor_pkg::ST_CLEAR;
               end else if (req_operation == pcor_pkg::OP_BOUND) begin
                  state_in = pcor_pkg::ST_BOX;
               end else begin
                  state_in = pcor_pkg::ST_LAUNCH;
               end
            end
         end
         pcor_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = pcor_pkg::ST_LAUNCH;
         end
         pcor_pkg::ST_BOX: begin
            state_in = pcor_pkg::ST_LAUNCH;
         end
         pcor_pkg::ST_LAUNCH: begin
            state_in = pcor_pkg::ST_DIVIDE;
         end
         pcor_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               unique case (step_ff)
                  pcor_pkg::SEL_WIDTH: begin
                     step_in = pcor_pkg::SEL_HEIGHT;
                     state_in = pcor_pkg::ST_LAUNCH;
                  end
                  pcor_pkg::SEL_HEIGHT: begin
                     if (is_place_op) begin
                        step_in = pcor_pkg::SEL_COL;
                        state_in = pcor_pkg::ST_LAUNCH;
                     end else if (status.operation == pcor_pkg::OP_READ) begin
                        state_in = pcor_pkg::ST_READ;
                     end else begin
                        state_in = pcor_pkg::ST_DONE;
                     end
                  end
                  pcor_pkg::SEL_COL: begin
                     step_in = pcor_pkg::SEL_ROW;
                     state_in = pcor_pkg::ST_LAUNCH;
                  end
                  pcor_pkg::SEL_ROW: begin
                     state_in = pcor_pkg::ST_PLACE;
                  end
               endcase
            end
         end
         pcor_pkg::ST_PLACE: begin
            state_in = pcor_pkg::ST_DONE;
         end
         pcor_pkg::ST_READ: begin
            state_in = pcor_pkg::ST_DONE;
         end
         pcor_pkg::ST_DONE: begin
            if (slot_free) state_in = pcor_pkg::ST_IDLE;
         end
         default: begin
            state_in = pcor_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = step_ff;
      unique case (state_ff)
         pcor_pkg::ST_INIT: cmd.clr_we = 1'b1;
         pcor_pkg::ST_IDLE: cmd.req_load = req_valid;
         pcor_pkg::ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            cmd.box_clear = 1'b1;
         end
         pcor_pkg::ST_BOX: cmd.box_update = 1'b1;
         pcor_pkg::ST_LAUNCH: cmd.div_start = 1'b1;
         pcor_pkg::ST_DIVIDE: cmd.div_latch = status.div_done;
         pcor_pkg::ST_PLACE: cmd.place_write = 1'b1;
         pcor_pkg::ST_READ: cmd.mem_read = 1'b1;
         pcor_pkg::ST_DONE: cmd.rsp_load = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcor_pkg::ST_INIT;
         step_ff <= pcor_pkg::SEL_WIDTH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != pcor_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/point_cloud_occupancy_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// point_cloud_occupancy_rasterizer_unit: occupancy grid point rasterizer
// Projects points in millimetres onto a grid of free, occupied and unknown
// cells, sized from a running bounding box and the programmable cell size.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall with one packed payload, and each
// request produces exactly one response on rsp_valid/rsp_stall. The user must
// write the cell size register over the APB-style port only while the block
// is idle; the block itself does not enforce this. Every request runs
// through one shared divider that resolves one quotient bit per cycle. Width
// and height take one division each; ground and obstacle points need two
// more divisions, for column and row. Bound requests add a box update step
// and read requests a memory read step. The next request is taken in the
// cycle after a response is loaded. A clear request first sweeps all
// MAX_ROWS * MAX_COLS cells of the grid memory, one cell a cycle, then
// reports like a status request. After reset the same clearing pass runs
// while req_stall stays high; register writes are taken throughout. A
// finished response waits in an output register while the receiver stalls,
// and the next request is accepted meanwhile; its own response is held back
// until the register is free.
// ----------------------------------------------------------------------------
module point_cloud_occupancy_rasterizer_unit #(
   parameter int MAX_COLS = pcor_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = pcor_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pcor_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pcor_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   pcor_pkg::cmd_type    cmd;
   pcor_pkg::status_type status;
   logic [15:0]          cell_size_ff, cell_size_in;

   always_comb begin
      cell_size_in = cell_size_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         cell_size_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= pcor_pkg::CELL_SIZE_RESET;
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {16'd0, cell_size_ff} : 32'd0;

   pcor_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_payload.operation),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .status       (status)
   );

   pcor_datapath #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_payload(req_payload),
      .cell_size  (cell_size_ff),
      .rsp_payload(rsp_payload)
   );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking test of point_cloud_occupancy_rasterizer_unit
// Drives directed and random point requests through the valid/stall channel
// and predicts every response from an internal model of the bounding box and
// the occupancy grid. Several cell sizes are programmed over the APB port
// between phases; both channels idle at random with a chance set per phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          GRID_COLS     = pcor_pkg::MAX_COLS_DEFAULT;
   localparam int          GRID_ROWS     = pcor_pkg::MAX_ROWS_DEFAULT;
   localparam logic [2:0]  CELL_SIZE_ADR = 3'd0;
   localparam logic [2:0]  OP_UNUSED_A   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_B   = 3'd6;
   localparam logic [2:0]  OP_UNUSED_C   = 3'd7;
   localparam int          CYCLE_LIMIT   = 6000000;
   localparam int          PHASE_ITEMS   = 240;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   pcor_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   pcor_pkg::rsp_payload_type rsp_payload;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [2:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   point_cloud_occupancy_rasterizer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pcor_pkg::req_payload_type pending_reqs[$];
   pcor_pkg::rsp_payload_type expected_rsps[$];

   logic [15:0] cell_mm = pcor_pkg::CELL_SIZE_RESET;
   longint      box_lo_x, box_hi_x, box_lo_y, box_hi_y;
   bit          box_on;
   bit   [1:0]  occ_map [0:GRID_ROWS*GRID_COLS-1];

   int  send_idle = 0;
   int  recv_idle = 0;
   int  mismatches = 0;
   int  cycles = 0;
   logic req_fire = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void clear_grid();
      box_lo_x = 0;
      box_hi_x = 0;
      box_lo_y = 0;
      box_hi_y = 0;
      box_on = 1'b0;
      for (int i = 0; i < GRID_ROWS * GRID_COLS; i++) occ_map[i] = pcor_pkg::CELL_UNKNOWN;
   endfunction

   function automatic longint cell_eff();
      return (cell_mm == 16'd0) ? 1 : longint'(cell_mm);
   endfunction

   function automatic pcor_pkg::rsp_payload_type rasterize(pcor_pkg::req_payload_type r);
      pcor_pkg::rsp_payload_type o;
      longint cs, px, py, w, h, den, col, row;
      o = '0;
      cs = cell_eff();
      px = longint'(r.point_x_mm);
      py = longint'(r.point_y_mm);
      if (r.operation == pcor_pkg::OP_CLEAR) begin
         clear_grid();
      end else if (r.operation == pcor_pkg::OP_BOUND) begin
         if (!box_on) begin
            box_lo_x = px;
            box_hi_x = px;
            box_lo_y = py;
            box_hi_y = py;
            box_on = 1'b1;
         end else begin
            if (px > box_hi_x) box_hi_x = px;
            if (px < box_lo_x) box_lo_x = px;
            if (py > box_hi_y) box_hi_y = py;
            if (py < box_lo_y) box_lo_y = py;
         end
      end
      w = box_on ? (box_hi_x - box_lo_x) / cs : 0;
      h = box_on ? (box_hi_y - box_lo_y) / cs : 0;
      if (w > GRID_COLS) w = GRID_COLS;
      if (h > GRID_ROWS) h = GRID_ROWS;
      if (r.operation == pcor_pkg::OP_GROUND || r.operation == pcor_pkg::OP_OBSTACLE) begin
         den = 2 * cs;
         col = (2 * px - (box_lo_x + box_hi_x) + (w / 2) * den) / den;
         row = (2 * py - (box_lo_y + box_hi_y) + (h / 2) * den) / den;
         if (col >= 0 && col < w && row >= 0 && row < h)
            occ_map[row * GRID_COLS + col] = (r.operation == pcor_pkg::OP_GROUND)
               ? pcor_pkg::CELL_FREE : pcor_pkg::CELL_OCCUPIED;
         else
            o.point_dropped = 1'b1;
      end else if (r.operation == pcor_pkg::OP_READ) begin
         o.cell_value = pcor_pkg::VALUE_UNKNOWN;
         if (longint'(r.read_row) < h && longint'(r.read_col) < w) begin
            case (occ_map[r.read_row * GRID_COLS + r.read_col])
               pcor_pkg::CELL_FREE:     o.cell_value = pcor_pkg::VALUE_FREE;
               pcor_pkg::CELL_OCCUPIED: o.cell_value = pcor_pkg::VALUE_OCCUPIED;
               default:                 o.cell_value = pcor_pkg::VALUE_UNKNOWN;
            endcase
         end
      end
      o.map_width = w[8:0];
      o.map_height = h[8:0];
      o.origin_x_mm = box_lo_x[23:0];
      o.origin_y_mm = box_lo_y[23:0];
      return o;
   endfunction

   function automatic void add_req(logic [2:0] op, longint x, longint y,
                                   logic [7:0] row, logic [7:0] col);
      pcor_pkg::req_payload_type r;
      r.operation = op;
      r.point_x_mm = x[23:0];
      r.point_y_mm = y[23:0];
      r.read_row = row;
      r.read_col = col;
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic void add_noise();
      logic [2:0] op;
      op = 3'($urandom_range(7));
      if (op == pcor_pkg::OP_CLEAR) op = 3'($urandom_range(OP_UNUSED_C, OP_UNUSED_A));
      add_req(op, longint'($urandom), longint'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   function automatic longint near(longint lo, longint span);
      return lo - span / 8 + longint'($urandom_range(int'(span * 5 / 4)));
   endfunction

   function automatic void fill_phase(int count);
      int made;
      longint span_x, span_y, lo_x, lo_y;
      logic [2:0] op;
      made = 0;
      add_req(pcor_pkg::OP_CLEAR, 0, 0, 8'd0, 8'd0);
      while (made < count) begin
         span_x = longint'($urandom_range(300, 1)) * cell_eff();
         span_y = longint'($urandom_range(300, 1)) * cell_eff();
         if (span_x > 6000000) span_x = 6000000;
         if (span_y > 6000000) span_y = 6000000;
         lo_x = longint'($urandom_range(4000000)) - 2000000 - span_x / 2;
         lo_y = longint'($urandom_range(4000000)) - 2000000 - span_y / 2;
         add_req(pcor_pkg::OP_BOUND, lo_x, lo_y, 8'($urandom), 8'($urandom));
         add_req(pcor_pkg::OP_BOUND, lo_x + span_x, lo_y + span_y,
                 8'($urandom), 8'($urandom));
         made += 2;
         repeat ($urandom_range(40, 10)) begin
            case ($urandom_range(9))
               0: add_noise();
               1: add_req(pcor_pkg::OP_READ, longint'($urandom), longint'($urandom),
                          8'($urandom), 8'($urandom));
               2: add_req(pcor_pkg::OP_READ, longint'($urandom), longint'($urandom),
                          8'($urandom_range(40)), 8'($urandom_range(40)));
               3: add_req(pcor_pkg::OP_BOUND, near(lo_x, span_x), near(lo_y, span_y),
                          8'($urandom), 8'($urandom));
               default: begin
                  op = $urandom_range(1) ? pcor_pkg::OP_GROUND : pcor_pkg::OP_OBSTACLE;
                  add_req(op, near(lo_x, span_x), near(lo_y, span_y),
                          8'($urandom), 8'($urandom));
               end
            endcase
            made++;
         end
      end
   endfunction

   task automatic write_cell_size(logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CELL_SIZE_ADR;
      pwdata <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cell_mm = value;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      pcor_pkg::rsp_payload_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("point_cloud_occupancy_rasterizer_unit test failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Response arrived with none expected.");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch c %0d/%0d d %0b/%0b w %0d/%0d h %0d/%0d",
                              want.cell_value, rsp_payload.cell_value,
                              want.point_dropped, rsp_payload.point_dropped,
                              want.map_width, rsp_payload.map_width,
                              want.map_height, rsp_payload.map_height,
                              " x %0d/%0d y %0d/%0d",
                              want.origin_x_mm, rsp_payload.origin_x_mm,
                              want.origin_y_mm, rsp_payload.origin_y_mm);
               end
            end
         end
         if (req_valid && !req_stall) expected_rsps = {expected_rsps, rasterize(req_payload)};
      end
      req_fire <= !reset && req_valid && !req_stall;
   end

   initial begin
      logic [15:0] sizes [6];
      clear_grid();
      sizes = '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd7, 16'($urandom_range(65534, 2))};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_cell_size(16'd100);
      add_req(pcor_pkg::OP_READ, 0, 0, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_GROUND, 0, 0, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_OBSTACLE, 5, -5, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_BOUND, -8388608, -8388608, 8'd255, 8'd255);
      add_req(pcor_pkg::OP_BOUND, 8388607, 8388607, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_GROUND, -8388608, -8388608, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_OBSTACLE, 8388607, 8388607, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_OBSTACLE, 8388507, 8388507, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_GROUND, 0, 0, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_READ, 0, 0, 8'd128, 8'd128);
      add_req(pcor_pkg::OP_READ, 0, 0, 8'd255, 8'd255);
      add_req(pcor_pkg::OP_READ, 0, 0, 8'd0, 8'd0);
      add_req(OP_UNUSED_A, 1, 1, 8'd1, 8'd1);
      add_req(OP_UNUSED_B, -1, -1, 8'd2, 8'd2);
      add_req(OP_UNUSED_C, 8388607, -8388608, 8'd255, 8'd0);
      add_req(pcor_pkg::OP_CLEAR, 0, 0, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_READ, 0, 0, 8'd128, 8'd128);
      add_req(pcor_pkg::OP_BOUND, 100, 100, 8'd0, 8'd0);
      add_req(pcor_pkg::OP_GROUND, 100, 100, 8'd0, 8'd0);
      wait_drained();
      for (int p = 0; p < 6; p++) begin
         send_idle = (p < 2) ? 29 : (p < 4) ? 87 : 0;
         recv_idle = (p < 2) ? 87 : (p < 4) ? 29 : 0;
         write_cell_size(sizes[p]);
         fill_phase(PHASE_ITEMS);
         wait_drained();
      end
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("point_cloud_occupancy_rasterizer_unit test passed");
      else
         $display("point_cloud_occupancy_rasterizer_unit test failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/pcor_pkg.sv
design/pcor_divider.sv
design/pcor_datapath.sv
design/pcor_controller.sv
design/point_cloud_occupancy_rasterizer_unit.sv
test/testbench.sv
